// File: rtl/core/matd_pkg.sv
`timescale 1ns / 1ps
// Package for the moving average threshold detector.
// Beat types, register indexes, codes and sizing constants; no dependencies.
package matd_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int POS_W      = $clog2(MAX_WINDOW);
  localparam int LEVEL_W    = 16;
  localparam int WIN_W      = 7;
  localparam int SUM_W      = 22;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_THRESH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESH   = 3'd5;

  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HYST   = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;

  typedef struct packed {
    logic               command;
    logic [LEVEL_W-1:0] sample_level;
  } in_beat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] current_level;
    logic [LEVEL_W-1:0] previous_level;
    logic               switch_on;
    logic               switch_changed;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [WIN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/moving_average_threshold_detector.sv
`timescale 1ns / 1ps
// Moving average threshold detector, top level. Uses matd_pkg and matd_div.
// Evaluate beats and unfiltered samples go straight from accept to S_DONE;
// filtered samples pass S_READ (ring read), S_SUM (sum update) and S_DIV (divider).
// S_DONE waits until out_data is free or being taken, then loads it and raises out_valid.
// One item at a time; in_ready returns in the same cycle that out_valid rises.
// Sync reset clears controls, registers, sum, position and ring valid bits.
module moving_average_threshold_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  matd_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output matd_pkg::out_beat_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [matd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [matd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import matd_pkg::*;

  state_t state, state_next;

  logic               filter_enable;
  logic [WIN_W-1:0]   window_size;
  logic [MODE_W-1:0]  detect_mode;
  logic [LEVEL_W-1:0] single_threshold;
  logic [LEVEL_W-1:0] low_threshold;
  logic [LEVEL_W-1:0] high_threshold;

  logic [LEVEL_W-1:0] ring [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] ring_vld;
  logic [LEVEL_W-1:0] rd_data;
  logic               rd_vld;

  logic [SUM_W-1:0]   running_sum;
  logic [POS_W-1:0]   ring_position;
  logic [POS_W-1:0]   pos;
  logic [LEVEL_W-1:0] sample;
  logic [LEVEL_W-1:0] level_now;
  logic [LEVEL_W-1:0] level_before;
  logic               switch_state;
  logic               changed;

  logic               in_acc;
  logic               cfg_acc;
  logic               filt_clear;
  logic [WIN_W-1:0]   win_eff;
  logic [WIN_W-1:0]   pos_inc;
  logic [POS_W-1:0]   pos_new;
  logic               sw_next;
  logic               eval_active;
  logic [LEVEL_W-1:0] old_val;
  logic [SUM_W-1:0]   sum_base;
  logic [SUM_W-1:0]   sum_new;
  logic [LEVEL_W-1:0] quo_sat;
  logic               out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign filt_clear = cfg_acc &&
                      (cfg_index == REG_FILTER_ENABLE || cfg_index == REG_WINDOW_SIZE);

  always_comb begin
    if (window_size == '0) begin
      win_eff = WIN_W'(1);
    end else if (window_size > WIN_W'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = window_size;
    end
    pos_inc = WIN_W'(ring_position) + WIN_W'(1);
    pos_new = (pos_inc >= win_eff) ? '0 : pos_inc[POS_W-1:0];
  end

  always_comb begin
    sw_next     = switch_state;
    eval_active = 1'b1;
    unique case (detect_mode)
      MODE_SINGLE: sw_next = (level_now >= single_threshold);
      MODE_HYST: begin
        if (level_now <= low_threshold) begin
          sw_next = 1'b0;
        end else if (level_now >= high_threshold) begin
          sw_next = 1'b1;
        end
      end
      default: eval_active = 1'b0;
    endcase
  end

  always_comb begin
    old_val  = rd_vld ? rd_data : '0;
    sum_base = (running_sum < SUM_W'(old_val)) ? '0 : running_sum - SUM_W'(old_val);
    sum_new  = sum_base + SUM_W'(sample);
    quo_sat  = (|div_rsp.quotient[SUM_W-1:LEVEL_W]) ? '1 : div_rsp.quotient[LEVEL_W-1:0];
    div_req.start    = (state == S_SUM);
    div_req.dividend = sum_new;
    div_req.divisor  = win_eff;
  end

  matd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.command == CMD_SAMPLE && filter_enable) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: state_next = S_SUM;
      S_SUM:  state_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable    <= 1'b0;
      window_size      <= WIN_W'(1);
      detect_mode      <= '0;
      single_threshold <= '0;
      low_threshold    <= '0;
      high_threshold   <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_FILTER_ENABLE: filter_enable    <= cfg_data[0];
        REG_WINDOW_SIZE:   window_size      <= cfg_data[WIN_W-1:0];
        REG_DETECT_MODE:   detect_mode      <= cfg_data[MODE_W-1:0];
        REG_SINGLE_THRESH: single_threshold <= cfg_data[LEVEL_W-1:0];
        REG_LOW_THRESH:    low_threshold    <= cfg_data[LEVEL_W-1:0];
        REG_HIGH_THRESH:   high_threshold   <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      ring[pos] <= sample;
    end
    rd_data <= ring[pos];
  end

  always_ff @(posedge clk) begin
    if (rst || filt_clear) begin
      ring_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= ring_vld[pos];
      if (state == S_SUM) begin
        ring_vld[pos] <= 1'b1;
      end
    end
  end

  // datapath and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      ring_position <= '0;
      level_now     <= '0;
      level_before  <= '0;
      switch_state  <= 1'b0;
      changed       <= 1'b0;
      out_valid     <= 1'b0;
      pos           <= '0;
    end else begin
      if (filt_clear) begin
        running_sum   <= '0;
        ring_position <= '0;
      end
      if (in_acc) begin
        changed <= 1'b0;
        sample  <= in_data.sample_level;
        pos     <= pos_new;
        if (in_data.command == CMD_SAMPLE) begin
          level_before <= level_now;
          if (!filter_enable) begin
            level_now <= in_data.sample_level;
          end
        end else if (eval_active && sw_next != switch_state) begin
          switch_state <= sw_next;
          changed      <= 1'b1;
        end
      end
      if (state == S_SUM) begin
        running_sum   <= sum_new;
        ring_position <= pos;
      end
      if (state == S_DIV && div_rsp.done) begin
        level_now <= quo_sat;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.current_level  <= level_now;
      out_data.previous_level <= level_before;
      out_data.switch_on      <= switch_state;
      out_data.switch_changed <= changed;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised without a finished item");

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> WIN_W'(ring_position) < win_eff)
    else $error("ring position outside the active window");

endmodule

// File: rtl/core/matd_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on matd_pkg for widths and the request/response structs.
module matd_div (
  input  logic               clk,
  input  logic               rst,
  input  matd_pkg::div_req_t req,
  output matd_pkg::div_rsp_t rsp
);
  import matd_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo;
  logic [WIN_W-1:0] rem;
  logic [WIN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [WIN_W:0]   shifted;
  logic             fits;
  logic [WIN_W:0]   diff;

  always_comb begin
    shifted = {rem, quo[SUM_W-1]};
    fits    = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: verif/tb_moving_average_threshold_detector.sv
`timescale 1ns / 1ps
// Testbench for moving_average_threshold_detector: directed and random sample/evaluate
// beats with random stalls on both sides, checked against a local level/switch tracker.
// Depends on matd_pkg and the detector RTL.
module tb_moving_average_threshold_detector;
  import matd_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RX_HOLD     = 300;
  localparam int PHASE_BEATS = 100;

  localparam logic [MODE_W-1:0]    MODE_OFF       = 2'd0;
  localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_0 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_1 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // tracker state and register shadow
  logic [LEVEL_W-1:0] avg_ring [MAX_WINDOW];
  logic [SUM_W-1:0]   avg_sum;
  logic [POS_W-1:0]   avg_pos;
  logic [LEVEL_W-1:0] lvl_now = '0;
  logic [LEVEL_W-1:0] lvl_prev = '0;
  logic               sw_state = 1'b0;
  logic               filt_en = 1'b0;
  logic [WIN_W-1:0]   win_reg = 7'd1;
  logic [MODE_W-1:0]  det_mode = MODE_OFF;
  logic [LEVEL_W-1:0] thr_single = '0;
  logic [LEVEL_W-1:0] thr_low = '0;
  logic [LEVEL_W-1:0] thr_high = '0;

  in_beat_t    items_to_send[$];
  out_beat_t   reports_due[$];
  int unsigned queued_items = 0;
  int unsigned accepted_items = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_ack = 0;
  bit          idle_on = 1'b1;

  moving_average_threshold_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_average();
    for (int i = 0; i < MAX_WINDOW; i++) avg_ring[i] = '0;
    avg_sum = '0;
    avg_pos = '0;
  endfunction

  function automatic out_beat_t predict_report(in_beat_t item);
    out_beat_t        rep;
    logic [WIN_W-1:0] span;
    logic [WIN_W-1:0] nxt;
    logic [SUM_W-1:0] quo;
    logic             sw_next;
    logic             armed;
    rep = '0;
    sw_next = sw_state;
    armed = 1'b0;
    if (item.command == CMD_SAMPLE) begin
      lvl_prev = lvl_now;
      if (filt_en) begin
        span = (win_reg == 0) ? 7'd1 : (win_reg > MAX_WINDOW) ? 7'(MAX_WINDOW) : win_reg;
        nxt = 7'(avg_pos) + 7'd1;
        if (nxt >= span) nxt = '0;
        // sum never goes below zero
        if (avg_sum < SUM_W'(avg_ring[nxt[POS_W-1:0]])) avg_sum = '0;
        else avg_sum = avg_sum - SUM_W'(avg_ring[nxt[POS_W-1:0]]);
        avg_sum = avg_sum + SUM_W'(item.sample_level);
        avg_ring[nxt[POS_W-1:0]] = item.sample_level;
        avg_pos = nxt[POS_W-1:0];
        quo = avg_sum / SUM_W'(span);
        lvl_now = (quo > 16'hFFFF) ? 16'hFFFF : quo[LEVEL_W-1:0];
      end else begin
        lvl_now = item.sample_level;
      end
    end else begin
      if (det_mode == MODE_SINGLE) begin
        armed = 1'b1;
        sw_next = (lvl_now >= thr_single);
      end else if (det_mode == MODE_HYST) begin
        armed = 1'b1;
        // low test wins when the thresholds overlap
        if (lvl_now <= thr_low) sw_next = 1'b0;
        else if (lvl_now >= thr_high) sw_next = 1'b1;
      end
      if (armed && sw_next != sw_state) begin
        sw_state = sw_next;
        rep.switch_changed = 1'b1;
      end
    end
    rep.current_level = lvl_now;
    rep.previous_level = lvl_prev;
    rep.switch_on = sw_state;
    return rep;
  endfunction

  function automatic void send_sample(logic [LEVEL_W-1:0] level);
    items_to_send.push_back(in_beat_t'{command: CMD_SAMPLE, sample_level: level});
    queued_items++;
  endfunction

  function automatic void send_eval();
    items_to_send.push_back(in_beat_t'{command: CMD_EVAL, sample_level: 16'($urandom)});
    queued_items++;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(thr_high + $urandom_range(0, 16) - 8);
      3: return 16'(thr_low + $urandom_range(0, 16) - 8);
      4: return 16'(thr_single + $urandom_range(0, 16) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FILTER_ENABLE: begin
        filt_en = value[0];
        clear_average();
      end
      REG_WINDOW_SIZE: begin
        win_reg = value[WIN_W-1:0];
        clear_average();
      end
      REG_DETECT_MODE:   det_mode = value[MODE_W-1:0];
      REG_SINGLE_THRESH: thr_single = value[LEVEL_W-1:0];
      REG_LOW_THRESH:    thr_low = value[LEVEL_W-1:0];
      REG_HIGH_THRESH:   thr_high = value[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (accepted_items != queued_items || reports_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        reports_due.push_back(predict_report(in_data));
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          in_data  <= items_to_send.pop_front();
          in_valid <= 1'b1;
          tx_gap   <= idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin : rx_side
    out_beat_t   want;
    int unsigned pick;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none got %h", $time, out_data);
        end else begin
          want = reports_due.pop_front();
          if (out_data.current_level !== want.current_level) begin
            errors++;
            $display("%0t: current_level expected %h got %h", $time,
                     want.current_level, out_data.current_level);
          end
          if (out_data.previous_level !== want.previous_level) begin
            errors++;
            $display("%0t: previous_level expected %h got %h", $time,
                     want.previous_level, out_data.previous_level);
          end
          if (out_data.switch_on !== want.switch_on) begin
            errors++;
            $display("%0t: switch_on expected %b got %b", $time,
                     want.switch_on, out_data.switch_on);
          end
          if (out_data.switch_changed !== want.switch_changed) begin
            errors++;
            $display("%0t: switch_changed expected %b got %b", $time,
                     want.switch_changed, out_data.switch_changed);
          end
        end
      end
      if (rx_hold_req != rx_hold_ack) begin
        rx_hold_ack <= rx_hold_req;
        rx_stall    <= RX_HOLD;
        out_ready   <= 1'b0;
      end else if (out_valid && out_ready) begin
        pick = idle_on ? $urandom_range(0, 7) : 0;
        rx_stall  <= pick;
        out_ready <= (pick == 0);
      end else if (rx_stall != 0) begin
        rx_stall  <= rx_stall - 1;
        out_ready <= (rx_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [WIN_W-1:0]   win;
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] low;
    logic [LEVEL_W-1:0] high;
    logic [LEVEL_W-1:0] single;
    logic               fe;
    clear_average();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // raw levels, detection off
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_eval();
    settle();

    write_reg(REG_DETECT_MODE, 16'(MODE_SINGLE));
    write_reg(REG_SINGLE_THRESH, 16'h8000);
    send_sample(16'h8000);
    send_eval();
    send_sample(16'h7FFF);
    send_eval();
    settle();

    write_reg(REG_DETECT_MODE, 16'(MODE_HYST));
    write_reg(REG_LOW_THRESH, 16'd100);
    write_reg(REG_HIGH_THRESH, 16'd200);
    send_sample(16'd150);
    send_eval();
    send_sample(16'd200);
    send_eval();
    send_sample(16'd100);
    send_eval();
    send_sample(16'd250);
    send_eval();
    settle();
    // overlap: level is both <= low and >= high
    write_reg(REG_LOW_THRESH, 16'd300);
    send_eval();
    settle();

    // spare mode through masked upper bits
    write_reg(REG_DETECT_MODE, 16'hFFFF);
    send_eval();
    settle();

    write_reg(REG_FILTER_ENABLE, 16'h0001);
    write_reg(REG_WINDOW_SIZE, 16'd3);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    settle();

    for (int p = 0; p < 10; p++) begin
      idle_on = (p % 3) != 2;
      case (p)
        0: win = 7'd1;
        1: win = 7'd64;
        2: win = 7'd0;
        3: win = 7'd127;
        4: win = 7'd2;
        default: win = 7'($urandom_range(1, 64));
      endcase
      fe = (p % 4) != 3;
      case (p)
        5: mode = MODE_OFF;
        8: mode = MODE_SPARE;
        default: mode = (p % 2) ? MODE_HYST : MODE_SINGLE;
      endcase
      single = (p == 0) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom);
      low = 16'($urandom_range(0, 60000));
      high = (p == 7) ? 16'(low - $urandom_range(0, 500)) : 16'(low + $urandom_range(0, 3000));
      if (p == 1) begin
        low = 16'h0000;
        high = 16'hFFFF;
      end else if (p == 3) begin
        low = 16'hFFFF;
        high = 16'h0000;
      end
      write_reg(REG_FILTER_ENABLE, {15'($urandom), fe});
      write_reg(REG_WINDOW_SIZE, {9'($urandom), win});
      write_reg(REG_DETECT_MODE, {14'($urandom), mode});
      write_reg(REG_SINGLE_THRESH, single);
      write_reg(REG_LOW_THRESH, low);
      write_reg(REG_HIGH_THRESH, high);
      write_reg((p % 2) ? REG_UNMAPPED_0 : REG_UNMAPPED_1, 16'($urandom));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 9) < 4) send_eval();
        else send_sample(pick_level());
      end
      // long receiver stall while beats keep coming
      if (p == 1) rx_hold_req++;
      settle();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
